@@ hdl/mlptr_pkg.sv @@
package mlptr_pkg;

    // field widths
    localparam int FEAT_W  = 16;
    localparam int TGT_W   = 17;
    localparam int MODE_W  = 2;
    localparam int WIDX_W  = 4;
    localparam int WVAL_W  = 24;
    localparam int LR_W    = 16;
    localparam int PRED_W  = 17;

    localparam logic [LR_W-1:0]  LR_RESET = 16'd6554;
    localparam logic [TGT_W-1:0] TGT_ONE  = 17'h10000;

    localparam int WEIGHT_WIDTH_DEF = 24;
    localparam int NUM_WEIGHTS      = 9;

    // sigmoid table
    localparam int SIG_TABLE_DEPTH = 256;
    localparam int SIG_IDX_W       = $clog2(SIG_TABLE_DEPTH);

    // shared multiplier operand and product widths
    localparam int MA_W = 40;
    localparam int MB_W = 18;
    localparam int P_W  = MA_W + MB_W;

    // sequencer steps
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_LAST_INFER = 5'd8;
    localparam logic [STEP_W-1:0] STEP_LAST_TRAIN = 5'd31;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_INFER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRAIN = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_WB,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              accept;
        logic              mul;
        logic              wb;
        logic              emit;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic in_load;
        logic is_train;
    } t_status;

    typedef logic [PRED_W-1:0] t_sig_entry;
    typedef t_sig_entry [SIG_TABLE_DEPTH-1:0] t_sig_table;

    // long division, only evaluated while building the constant table
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-a) in q.30, a in q.16
    function automatic logic [63:0] exp_neg(input logic [63:0] a);
        logic [63:0]        y;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        y    = a << 10;
        term = 64'd1 << 30;
        sum  = signed'(term);
        for (int k = 1; k <= 12; k++) begin
            term = udiv64((term * y) >> 30, 64'(k));
            if (k % 2 == 1) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        r = (sum > 0) ? unsigned'(sum) : 64'd0;
        for (int k = 0; k < 4; k++) begin
            r = (r * r) >> 30;
        end
        return r;
    endfunction

    function automatic t_sig_entry sig_exact(input logic signed [63:0] x);
        logic [63:0] a;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] q;
        a   = (x < 0) ? unsigned'(-x) : unsigned'(x);
        e   = exp_neg(a);
        den = (64'd1 << 30) + e;
        if (x >= 0) begin
            q = udiv64((64'd1 << 46) + (den >> 1), den);
        end else begin
            q = udiv64((e << 16) + (den >> 1), den);
        end
        return q[PRED_W-1:0];
    endfunction

    // each entry is the sigmoid at the centre of its bin over [-8,8)
    function automatic t_sig_table build_sig_table();
        t_sig_table t;
        longint     xv;
        for (int i = 0; i < SIG_TABLE_DEPTH; i++) begin
            xv   = -64'sd524288 + ((2 * longint'(i) + 1) * 524288) / SIG_TABLE_DEPTH;
            t[i] = sig_exact(xv);
        end
        return t;
    endfunction

    localparam t_sig_table SIG_TABLE = build_sig_table();

endpackage

@@ hdl/mlp_2_2_1_sgd_trainer_core.sv @@
// 2-2-1 sigmoid network, online trainer and evaluator
//
// input channel: i_in_valid / o_in_stall, one transfer per item carrying mode,
//   both features, target and a weight index and value for loads
// output channel: o_out_valid / i_out_stall, one result transfer per item
// config: i_cfg_wr_en / i_cfg_wr_data write the learning rate, no wait
//
// from input transfer to result valid: a load goes straight to the output
//   load; infer runs nine steps of the shared multiplier, each a multiply
//   state and a writeback state, then the output load; train runs
//   thirty-two such steps (forward pass, derivatives, backprop, nine
//   updates), then the output load
// one item is in work at a time and the next transfer can follow in the
//   cycle after the result loads
// the next item is taken as soon as the result sits in the output register,
//   so a stalled receiver only holds the block once a second result is done
// reset clears all nine weights to zero, sets the learning rate to 6554 and
//   empties the output register
module mlp_2_2_1_sgd_trainer_core #(
    parameter int WEIGHT_WIDTH = mlptr_pkg::WEIGHT_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [mlptr_pkg::LR_W-1:0]           i_cfg_wr_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [mlptr_pkg::MODE_W-1:0]         i_mode,
    input  logic signed [mlptr_pkg::FEAT_W-1:0]  i_feature_a,
    input  logic signed [mlptr_pkg::FEAT_W-1:0]  i_feature_b,
    input  logic [mlptr_pkg::TGT_W-1:0]          i_target,
    input  logic [mlptr_pkg::WIDX_W-1:0]         i_weight_index,
    input  logic signed [mlptr_pkg::WVAL_W-1:0]  i_weight_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [mlptr_pkg::PRED_W-1:0]         o_prediction,
    output logic                                 o_weight_saturated
);
    import mlptr_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer: steps the shared multiplier and holds the result handshake
    mlptr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // weights, learning rate, multiplier, sigmoid table and temporaries
    mlptr_dp #(
        .WEIGHT_WIDTH (WEIGHT_WIDTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_mode             (i_mode),
        .i_feature_a        (i_feature_a),
        .i_feature_b        (i_feature_b),
        .i_target           (i_target),
        .i_weight_index     (i_weight_index),
        .i_weight_value     (i_weight_value),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_prediction       (o_prediction),
        .o_weight_saturated (o_weight_saturated)
    );

    // an accepted item always holds the input side in the cycle after its transfer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not held after transfer");

    // a sigmoid output never exceeds one
    a_pred_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_prediction <= TGT_ONE))
        else $error("prediction above one");

    // a new result only appears while an item is in work
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without an item in work");

endmodule

@@ hdl/mlptr_ctrl.sv @@
module mlptr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  mlptr_pkg::t_status   i_status,
    output mlptr_pkg::t_cmd      o_cmd
);
    import mlptr_pkg::*;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              accept, out_free, last;

    assign accept   = (r_state == ST_IDLE) && i_in_valid;
    assign out_free = !r_out_valid || !i_out_stall;
    assign last     = i_status.is_train ? (r_step == STEP_LAST_TRAIN)
                                        : (r_step == STEP_LAST_INFER);

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_step  = '0;
                    n_state = i_status.in_load ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_WB;
            end
            ST_WB: begin
                if (last) begin
                    n_state = ST_DONE;
                end else begin
                    n_step  = r_step + 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd.accept = accept;
        o_cmd.mul    = (r_state == ST_MUL);
        o_cmd.wb     = (r_state == ST_WB);
        o_cmd.emit   = (r_state == ST_DONE) && out_free;
        o_cmd.step   = r_step;
        o_in_stall   = (r_state != ST_IDLE);
        n_out_valid  = o_cmd.emit || (r_out_valid && i_out_stall);
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ hdl/mlptr_dp.sv @@
module mlptr_dp #(
    parameter int WEIGHT_WIDTH = mlptr_pkg::WEIGHT_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [mlptr_pkg::LR_W-1:0]           i_cfg_wr_data,
    input  logic [mlptr_pkg::MODE_W-1:0]         i_mode,
    input  logic signed [mlptr_pkg::FEAT_W-1:0]  i_feature_a,
    input  logic signed [mlptr_pkg::FEAT_W-1:0]  i_feature_b,
    input  logic [mlptr_pkg::TGT_W-1:0]          i_target,
    input  logic [mlptr_pkg::WIDX_W-1:0]         i_weight_index,
    input  logic signed [mlptr_pkg::WVAL_W-1:0]  i_weight_value,
    input  mlptr_pkg::t_cmd                      i_cmd,
    output mlptr_pkg::t_status                   o_status,
    output logic [mlptr_pkg::PRED_W-1:0]         o_prediction,
    output logic                                 o_weight_saturated
);
    import mlptr_pkg::*;

    localparam int DW = P_W - 15;
    localparam logic signed [DW-1:0] W_HI =
        {{(DW-WEIGHT_WIDTH+1){1'b0}}, {(WEIGHT_WIDTH-1){1'b1}}};
    localparam logic signed [DW-1:0] W_LO =
        {{(DW-WEIGHT_WIDTH+1){1'b1}}, {(WEIGHT_WIDTH-1){1'b0}}};

    logic [LR_W-1:0]                r_lr;
    logic signed [WEIGHT_WIDTH-1:0] r_w [NUM_WEIGHTS];
    logic [MODE_W-1:0]              r_mode;
    logic signed [FEAT_W-1:0]       r_xa, r_xb;
    logic [TGT_W-1:0]               r_tgt;
    logic signed [P_W-1:0]          r_p, r_acc;
    logic [PRED_W-1:0]              r_h1, r_h2, r_o, r_dh1, r_dh2, r_do;
    logic signed [MA_W-1:0]         r_go, r_gh, r_gh1, r_gh2, r_grad;
    logic                           r_sat;
    logic [PRED_W-1:0]              r_pred;
    logic                           r_sat_out;

    logic signed [MA_W-1:0]   a_op;
    logic signed [MB_W-1:0]   b_op;
    logic [PRED_W-1:0]        f_sel;
    logic signed [MB_W-1:0]   one_minus_f;
    logic signed [TGT_W+1:0]  d_err;
    logic                     w_we, upd_en;
    logic [WIDX_W-1:0]        w_idx;
    logic signed [DW-1:0]     sat_in, sat_out;
    logic                     sat_clip;

    function automatic logic [PRED_W-1:0] sig_of(input logic signed [P_W-1:0] s);
        logic [19:0]             off;
        logic [20+SIG_IDX_W-1:0] prod;
        logic [SIG_IDX_W-1:0]    idx;
        off  = s[19:0] + 20'h80000;
        prod = (20+SIG_IDX_W)'(off) * (20+SIG_IDX_W)'(SIG_TABLE_DEPTH);
        idx  = prod[20+SIG_IDX_W-1:20];
        if (s < -P_W'(524288)) begin
            idx = '0;
        end else if (s >= P_W'(524288)) begin
            idx = SIG_IDX_W'(SIG_TABLE_DEPTH - 1);
        end
        return SIG_TABLE[idx];
    endfunction

    assign o_status.in_load  = (i_mode == MODE_LOAD);
    assign o_status.is_train = (r_mode == MODE_TRAIN);

    // 2*(o - target)
    assign d_err = {signed'({1'b0, r_o}) - signed'({1'b0, r_tgt}), 1'b0};

    // operand select for the shared multiplier
    always_comb begin
        a_op  = '0;
        b_op  = '0;
        f_sel = r_o;
        unique case (i_cmd.step)
            5'd11:   f_sel = r_h1;
            5'd12:   f_sel = r_h2;
            default: f_sel = r_o;
        endcase
        one_minus_f = signed'(MB_W'(18'h10000 - {1'b0, f_sel}));
        unique case (i_cmd.step)
            5'd0:  begin a_op = MA_W'(r_w[0]); b_op = MB_W'(r_xa); end
            5'd1:  begin a_op = MA_W'(r_w[1]); b_op = MB_W'(r_xb); end
            5'd3:  begin a_op = MA_W'(r_w[2]); b_op = MB_W'(r_xa); end
            5'd4:  begin a_op = MA_W'(r_w[3]); b_op = MB_W'(r_xb); end
            5'd6:  begin a_op = MA_W'(r_w[4]); b_op = MB_W'(signed'({1'b0, r_h1})); end
            5'd7:  begin a_op = MA_W'(r_w[5]); b_op = MB_W'(signed'({1'b0, r_h2})); end
            5'd9, 5'd11, 5'd12: begin
                a_op = MA_W'(signed'({1'b0, f_sel}));
                b_op = one_minus_f;
            end
            5'd10: begin a_op = MA_W'(d_err); b_op = MB_W'(signed'({1'b0, r_do})); end
            5'd13: begin a_op = MA_W'(r_w[4]); b_op = MB_W'(r_go); end
            5'd14: begin a_op = r_gh; b_op = MB_W'(signed'({1'b0, r_dh1})); end
            5'd15: begin a_op = MA_W'(r_w[5]); b_op = MB_W'(r_go); end
            5'd16: begin a_op = r_gh; b_op = MB_W'(signed'({1'b0, r_dh2})); end
            5'd17: begin a_op = r_gh1; b_op = MB_W'(r_xa); end
            5'd19: begin a_op = r_gh1; b_op = MB_W'(r_xb); end
            5'd21: begin a_op = r_gh2; b_op = MB_W'(r_xa); end
            5'd23: begin a_op = r_gh2; b_op = MB_W'(r_xb); end
            5'd25: begin a_op = r_go; b_op = MB_W'(signed'({1'b0, r_h1})); end
            5'd27: begin a_op = r_go; b_op = MB_W'(signed'({1'b0, r_h2})); end
            5'd18, 5'd20, 5'd22, 5'd24, 5'd26, 5'd28: begin
                a_op = r_grad;
                b_op = MB_W'(signed'({1'b0, r_lr}));
            end
            5'd29: begin a_op = r_gh1; b_op = MB_W'(signed'({1'b0, r_lr})); end
            5'd30: begin a_op = r_gh2; b_op = MB_W'(signed'({1'b0, r_lr})); end
            5'd31: begin a_op = r_go;  b_op = MB_W'(signed'({1'b0, r_lr})); end
            default: begin a_op = '0; b_op = '0; end
        endcase
    end

    // weight write port: load on accept, or a gradient step
    always_comb begin
        upd_en = 1'b0;
        w_idx  = i_weight_index;
        unique case (i_cmd.step)
            5'd18: begin upd_en = 1'b1; w_idx = 4'd0; end
            5'd20: begin upd_en = 1'b1; w_idx = 4'd1; end
            5'd22: begin upd_en = 1'b1; w_idx = 4'd2; end
            5'd24: begin upd_en = 1'b1; w_idx = 4'd3; end
            5'd26: begin upd_en = 1'b1; w_idx = 4'd4; end
            5'd28: begin upd_en = 1'b1; w_idx = 4'd5; end
            5'd29: begin upd_en = 1'b1; w_idx = 4'd6; end
            5'd30: begin upd_en = 1'b1; w_idx = 4'd7; end
            5'd31: begin upd_en = 1'b1; w_idx = 4'd8; end
            default: upd_en = 1'b0;
        endcase
        upd_en = upd_en && i_cmd.wb;
        if (!upd_en) begin
            w_idx = i_weight_index;
        end
        w_we = upd_en ||
               (i_cmd.accept && (i_mode == MODE_LOAD) && (i_weight_index < 4'(NUM_WEIGHTS)));
        if (upd_en) begin
            sat_in = DW'(r_w[w_idx]) - DW'(r_p >>> 16);
        end else begin
            sat_in = DW'(i_weight_value);
        end
        sat_clip = 1'b0;
        sat_out  = sat_in;
        if (sat_in > W_HI) begin
            sat_out  = W_HI;
            sat_clip = 1'b1;
        end else if (sat_in < W_LO) begin
            sat_out  = W_LO;
            sat_clip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr <= LR_RESET;
            for (int i = 0; i < NUM_WEIGHTS; i++) begin
                r_w[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_lr <= i_cfg_wr_data;
            end
            if (w_we) begin
                r_w[w_idx] <= sat_out[WEIGHT_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= i_mode;
            r_xa   <= i_feature_a;
            r_xb   <= i_feature_b;
            r_tgt  <= (i_target > TGT_ONE) ? TGT_ONE : i_target;
            r_sat  <= w_we && sat_clip;
        end
        if (i_cmd.mul) begin
            r_p <= a_op * b_op;
        end
        if (i_cmd.wb) begin
            unique case (i_cmd.step)
                5'd0:  r_acc <= (P_W'(r_w[6]) <<< 8) + r_p;
                5'd3:  r_acc <= (P_W'(r_w[7]) <<< 8) + r_p;
                5'd6:  r_acc <= (P_W'(r_w[8]) <<< 16) + r_p;
                5'd1, 5'd4, 5'd7: r_acc <= r_acc + r_p;
                5'd2:  r_h1 <= sig_of(r_acc >>> 8);
                5'd5:  r_h2 <= sig_of(r_acc >>> 8);
                5'd8:  r_o  <= sig_of(r_acc >>> 16);
                5'd9:  r_do  <= PRED_W'(r_p >>> 16);
                5'd11: r_dh1 <= PRED_W'(r_p >>> 16);
                5'd12: r_dh2 <= PRED_W'(r_p >>> 16);
                5'd10: r_go  <= MA_W'(r_p >>> 16);
                5'd13, 5'd15: r_gh <= MA_W'(r_p >>> 16);
                5'd14: r_gh1 <= MA_W'(r_p >>> 16);
                5'd16: r_gh2 <= MA_W'(r_p >>> 16);
                5'd17, 5'd19, 5'd21, 5'd23: r_grad <= MA_W'(r_p >>> 8);
                5'd25, 5'd27: r_grad <= MA_W'(r_p >>> 16);
                default: r_sat <= r_sat || (upd_en && sat_clip);
            endcase
        end
        if (i_cmd.emit) begin
            r_pred    <= (r_mode == MODE_LOAD) ? '0 : r_o;
            r_sat_out <= r_sat;
        end
    end

    assign o_prediction       = r_pred;
    assign o_weight_saturated = r_sat_out;

endmodule
